@@ rtl/tcg_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared constants, operation codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package tcg_pkg;

   localparam int CODE_W     = 7;
   localparam int LEN_W      = 5;
   localparam int POS_W      = 4;
   localparam int ROW_W      = 4;
   localparam int PIX_W      = 8;
   localparam int OP_W       = 2;
   localparam int PAGE_COUNT = 8;
   localparam int PAGE_ROWS  = 8;
   localparam int GLYPH_COUNT = 95;
   localparam int GLYPH_WIDTH = 8;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_GLYPH = 2'd2;

   localparam logic [CODE_W-1:0] CODE_NEWLINE    = 7'd10;
   localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 7'd32;
   localparam logic [CODE_W-1:0] LAST_PRINTABLE  = 7'd126;

   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] code;
   } put_cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] ch;
   } line_rd_type;

   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] index;
      logic [ROW_W-1:0]  row;
      logic [PIX_W-1:0]  bits;
   } glyph_wr_type;

   function automatic logic is_printable(input logic [CODE_W-1:0] code);
      return (code >= FIRST_PRINTABLE) && (code <= LAST_PRINTABLE);
   endfunction

endpackage

@@ rtl/tcg_glyph_mem.sv @@
// ----------------------------------------------------------------------------
// Glyph store
// One-write, one-read memory holding GLYPH_HEIGHT rows for each glyph.
// ----------------------------------------------------------------------------
module tcg_glyph_mem #(
   parameter int GLYPH_HEIGHT = 14
) (
   input  logic                              clock,
   input  tcg_pkg::glyph_wr_type             wr,
   input  logic                              rd_en,
   input  logic [tcg_pkg::CODE_W-1:0]        rd_index,
   input  logic [tcg_pkg::ROW_W-1:0]         rd_row,
   output logic [tcg_pkg::PIX_W-1:0]         rd_bits
);
   import tcg_pkg::*;

   localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int GAW   = $clog2(DEPTH);

   logic [PIX_W-1:0] glyph_mem_ff [DEPTH];
   logic [PIX_W-1:0] rd_bits_ff;
   logic [GAW-1:0]   wr_addr;
   logic [GAW-1:0]   rd_addr;
   logic             wr_ok;

   // Writes outside the glyph set or at or past the glyph height are dropped.
   assign wr_ok   = wr.en && (wr.index < GLYPH_COUNT) && (wr.row < GLYPH_HEIGHT);
   assign wr_addr = GAW'(int'(wr.index) * GLYPH_HEIGHT + int'(wr.row));
   assign rd_addr = GAW'(int'(rd_index) * GLYPH_HEIGHT + int'(rd_row));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         glyph_mem_ff[wr_addr] <= wr.bits;
      end
      if (rd_en) begin
         rd_bits_ff <= glyph_mem_ff[rd_addr];
      end
   end

   assign rd_bits = rd_bits_ff;

endmodule

@@ rtl/tcg_line_store.sv @@
// ----------------------------------------------------------------------------
// Line ring
// Character and length memories of the line ring, with the cursor and the
// top-of-window pointer, and the put-character update.
// ----------------------------------------------------------------------------
module tcg_line_store #(
   parameter int RING_LINES    = 8,
   parameter int VISIBLE_LINES = 4,
   parameter int LINE_CHARS    = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcg_pkg::put_cmd_type              put,
   input  logic                              rd_en,
   input  logic [$clog2(RING_LINES)-1:0]     rd_line,
   input  logic [tcg_pkg::POS_W-1:0]         rd_pos,
   output tcg_pkg::line_rd_type              rd_data,
   output logic [$clog2(RING_LINES)-1:0]     top_line
);
   import tcg_pkg::*;

   localparam int LW         = $clog2(RING_LINES);
   localparam int CHAR_DEPTH = RING_LINES * LINE_CHARS;
   localparam int CAW        = $clog2(CHAR_DEPTH);

   logic [CODE_W-1:0]     char_mem_ff [CHAR_DEPTH];
   logic [LEN_W-1:0]      len_mem_ff  [RING_LINES];
   logic [RING_LINES-1:0] len_vld_ff, len_vld_in;

   logic [LW-1:0]    cur_line_ff, cur_line_in;
   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic [LW-1:0]    top_line_ff, top_line_in;

   logic [CODE_W-1:0] rd_ch_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic              rd_vld_ff;

   logic             newline, printable, wrap, advance;
   logic [LW-1:0]    nxt_line, line_w;
   logic [LEN_W-1:0] len_base, len_wdata;
   logic [LW:0]      ring_gap;
   logic [LW:0]      cur_dist;
   logic             char_we, len_we;
   logic [CAW-1:0]   char_waddr, char_raddr;

   always_comb begin
      newline   = put.en && (put.code == CODE_NEWLINE);
      printable = put.en && is_printable(put.code);
      wrap      = printable && (cur_len_ff >= LINE_CHARS);
      advance   = newline || wrap;
      nxt_line  = (cur_line_ff == LW'(RING_LINES - 1)) ? '0 : cur_line_ff + 1'b1;
      line_w    = advance ? nxt_line : cur_line_ff;
      len_base  = advance ? '0 : cur_len_ff;
      len_wdata = newline ? '0 : len_base + 1'b1;
      char_we   = printable;
      len_we    = newline || printable;
      char_waddr = CAW'(int'(line_w) * LINE_CHARS + int'(len_base));

      // Ring distance from the window top to the new current line.
      if (nxt_line >= top_line_ff) begin
         ring_gap = {1'b0, nxt_line} - {1'b0, top_line_ff};
      end else begin
         ring_gap = (LW+1)'(int'(nxt_line) + RING_LINES - int'(top_line_ff));
      end

      cur_line_in = line_w;
      cur_len_in  = len_we ? len_wdata : cur_len_ff;
      top_line_in = top_line_ff;
      if (advance && (ring_gap >= VISIBLE_LINES)) begin
         top_line_in = (top_line_ff == LW'(RING_LINES - 1)) ? '0 : top_line_ff + 1'b1;
      end

      len_vld_in = len_vld_ff;
      if (len_we) begin
         len_vld_in[line_w] = 1'b1;
      end

      char_raddr = (rd_pos < LINE_CHARS) ?
                   CAW'(int'(rd_line) * LINE_CHARS + int'(rd_pos)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_line_ff <= '0;
         cur_len_ff  <= '0;
         top_line_ff <= '0;
         len_vld_ff  <= '0;
      end else begin
         cur_line_ff <= cur_line_in;
         cur_len_ff  <= cur_len_in;
         top_line_ff <= top_line_in;
         len_vld_ff  <= len_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem_ff[char_waddr] <= put.code;
      end
      if (len_we) begin
         len_mem_ff[line_w] <= len_wdata;
      end
      if (rd_en) begin
         rd_ch_ff  <= char_mem_ff[char_raddr];
         rd_len_ff <= len_mem_ff[rd_line];
         rd_vld_ff <= len_vld_ff[rd_line];
      end
   end

   // A line never written since reset has length zero.
   assign rd_data.len = rd_vld_ff ? rd_len_ff : '0;
   assign rd_data.ch  = rd_ch_ff;
   assign top_line    = top_line_ff;

   always_comb begin
      if (cur_line_ff >= top_line_ff) begin
         cur_dist = {1'b0, cur_line_ff} - {1'b0, top_line_ff};
      end else begin
         cur_dist = (LW+1)'(int'(cur_line_ff) + RING_LINES - int'(top_line_ff));
      end
   end

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff <= LINE_CHARS)
      else $error("current line length exceeds the line size");

   a_window: assert property (@(posedge clock) disable iff (reset)
      cur_dist < VISIBLE_LINES)
      else $error("current line lies outside the visible window");

   a_top_hold: assert property (@(posedge clock) disable iff (reset)
      !put.en |=> $stable(top_line_ff))
      else $error("window top moved without a put");
`endif

endmodule

@@ rtl/text_console_glyph_renderer_top.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Scrolling text console with on-demand rendering of display bytes.
// ----------------------------------------------------------------------------
// A put or a glyph write is done at the edge that accepts it and busy stays
// low, so such items can be given every cycle while busy is low. A display
// read raises busy until its byte is done and delivers the byte on
// rsp_pixel_byte with rsp_valid high for one cycle, as busy falls; a new read
// is taken only once the last one is through. A read makes one lookup per
// pixel row of the byte: eight rows issued one a cycle through the line
// memory and then the single read port of the glyph memory, over two
// register stages of lookup. The receiver cannot stall the result, and no
// clearing pass follows reset.
module text_console_glyph_renderer_top #(
   parameter int RING_LINES    = 8,
   parameter int VISIBLE_LINES = 4,
   parameter int LINE_CHARS    = 16,
   parameter int GLYPH_HEIGHT  = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tcg_pkg::OP_W-1:0]         req_operation,
   input  logic [tcg_pkg::CODE_W-1:0]       req_char_code,
   input  logic [2:0]                       req_page,
   input  logic [6:0]                       req_column,
   input  logic [tcg_pkg::CODE_W-1:0]       req_glyph_index,
   input  logic [tcg_pkg::ROW_W-1:0]        req_glyph_row,
   input  logic [tcg_pkg::PIX_W-1:0]        req_glyph_bits,
   output logic                             rsp_valid,
   output logic [tcg_pkg::PIX_W-1:0]        rsp_pixel_byte
);
   import tcg_pkg::*;

   localparam int LW = $clog2(RING_LINES);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [2:0]        bitsel_ff, bitsel_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [2:0]        vis_ff, vis_in;
   logic [LW-1:0]     lptr_ff, lptr_in;

   logic              s1_vld_ff, s1_vld_in;
   logic              s1_last_ff;
   logic              s1_inr_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s2_vld_ff, s2_vld_in;
   logic              s2_last_ff;
   logic              s2_hit_ff;
   logic [PIX_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_byte_ff;

   logic [2:0]        page_vis [PAGE_COUNT];
   logic [ROW_W-1:0]  page_row [PAGE_COUNT];

   logic              accept, read_go, issuing, hit, pix;
   logic [LW-1:0]     lptr_init, top_line;
   logic [2:0]        vis0;
   put_cmd_type       put;
   glyph_wr_type      glyph_wr;
   line_rd_type       line_rd;
   logic [PIX_W-1:0]  glyph_bits;
   logic [CODE_W-1:0] glyph_index;

   // First visible line and glyph row of each page, fixed at elaboration.
   for (genvar p = 0; p < PAGE_COUNT; p++) begin : g_page
      assign page_vis[p] = 3'((p * PAGE_ROWS) / GLYPH_HEIGHT);
      assign page_row[p] = ROW_W'((p * PAGE_ROWS) % GLYPH_HEIGHT);
   end

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign read_go = accept && (req_operation == OP_READ);
   assign issuing = (state_ff == ST_ISSUE);

   assign put.en         = accept && (req_operation == OP_PUT);
   assign put.code       = req_char_code;
   assign glyph_wr.en    = accept && (req_operation == OP_GLYPH);
   assign glyph_wr.index = req_glyph_index;
   assign glyph_wr.row   = req_glyph_row;
   assign glyph_wr.bits  = req_glyph_bits;

   tcg_line_store #(
      .RING_LINES   (RING_LINES),
      .VISIBLE_LINES(VISIBLE_LINES),
      .LINE_CHARS   (LINE_CHARS)
   ) u_lines (
      .clock   (clock),
      .reset   (reset),
      .put     (put),
      .rd_en   (issuing),
      .rd_line (lptr_ff),
      .rd_pos  (pos_ff),
      .rd_data (line_rd),
      .top_line(top_line)
   );

   // Stage one: the line memory answered; decide whether the pixel can be lit.
   assign hit = s1_vld_ff && s1_inr_ff && ({1'b0, pos_ff} < line_rd.len)
                && is_printable(line_rd.ch);
   assign glyph_index = line_rd.ch - FIRST_PRINTABLE;

   tcg_glyph_mem #(
      .GLYPH_HEIGHT(GLYPH_HEIGHT)
   ) u_glyphs (
      .clock   (clock),
      .wr      (glyph_wr),
      .rd_en   (hit),
      .rd_index(glyph_index),
      .rd_row  (s1_row_ff),
      .rd_bits (glyph_bits)
   );

   // Stage two: pick the column's bit out of the glyph row.
   assign pix = s2_hit_ff && glyph_bits[bitsel_ff];

   always_comb begin
      // Step from the window top to the line holding the first row of the page.
      vis0      = page_vis[req_page];
      lptr_init = top_line;
      for (int i = 0; i < VISIBLE_LINES - 1; i++) begin
         if (3'(i) < vis0) begin
            lptr_init = (lptr_init == LW'(RING_LINES - 1)) ? '0 : lptr_init + 1'b1;
         end
      end

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      bitsel_in = bitsel_ff;
      row_in    = row_ff;
      vis_in    = vis_ff;
      lptr_in   = lptr_ff;
      s1_vld_in = issuing;
      s2_vld_in = s1_vld_ff;
      acc_in    = acc_ff;
      rsp_valid_in = 1'b0;

      if (s2_vld_ff) begin
         acc_in = {pix, acc_ff[PIX_W-1:1]};
      end

      case (state_ff)
         ST_IDLE: begin
            if (read_go) begin
               state_in  = ST_ISSUE;
               cnt_in    = '0;
               pos_in    = req_column[6:3];
               bitsel_in = 3'(GLYPH_WIDTH - 1) - req_column[2:0];
               row_in    = page_row[req_page];
               vis_in    = vis0;
               lptr_in   = lptr_init;
            end
         end
         ST_ISSUE: begin
            cnt_in = cnt_ff + 1'b1;
            if (row_ff == ROW_W'(GLYPH_HEIGHT - 1)) begin
               row_in  = '0;
               vis_in  = vis_ff + 1'b1;
               lptr_in = (lptr_ff == LW'(RING_LINES - 1)) ? '0 : lptr_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
            if (cnt_ff == 3'(PAGE_ROWS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_vld_ff && s2_last_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      pos_ff     <= pos_in;
      bitsel_ff  <= bitsel_in;
      row_ff     <= row_in;
      vis_ff     <= vis_in;
      lptr_ff    <= lptr_in;
      s1_last_ff <= (cnt_ff == 3'(PAGE_ROWS - 1));
      s1_inr_ff  <= (vis_ff < VISIBLE_LINES);
      s1_row_ff  <= row_ff;
      s2_last_ff <= s1_last_ff;
      s2_hit_ff  <= hit;
      acc_ff     <= acc_in;
      if (rsp_valid_in) begin
         rsp_byte_ff <= acc_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_byte_ff;

`ifndef SYNTHESIS
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      read_go |-> ##11 rsp_valid)
      else $error("display read did not deliver its byte on time");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while a read is still in progress");

   a_busy_read: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(req_operation) == OP_READ)
      else $error("busy raised by an item that is not a read");
`endif

endmodule

@@ sim/tb_text_console_glyph_renderer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Drives put, display read and glyph load items through the start/busy port,
// keeps its own copy of the line ring and the glyph store to predict each display byte
// that no directed row gives outright, and compares each strobed byte with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer_top;
   import tcg_pkg::*;

   localparam int RING_LINES    = 8;
   localparam int VISIBLE_LINES = 4;
   localparam int LINE_CHARS    = 16;
   localparam int GLYPH_HEIGHT  = 14;
   localparam int GLYPH_SLOTS   = GLYPH_COUNT * GLYPH_HEIGHT;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int ITEM_BUDGET  = 1300;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CODE_W-1:0] code;
      logic [2:0]        page;
      logic [6:0]        column;
      logic [CODE_W-1:0] glyph_index;
      logic [ROW_W-1:0]  glyph_row;
      logic [PIX_W-1:0]  glyph_bits;
      logic              known;
      logic [PIX_W-1:0]  known_byte;
   } console_cmd_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [OP_W-1:0]   req_operation = '0;
   logic [CODE_W-1:0] req_char_code = '0;
   logic [2:0]        req_page = '0;
   logic [6:0]        req_column = '0;
   logic [CODE_W-1:0] req_glyph_index = '0;
   logic [ROW_W-1:0]  req_glyph_row = '0;
   logic [PIX_W-1:0]  req_glyph_bits = '0;
   logic              rsp_valid;
   logic [PIX_W-1:0]  rsp_pixel_byte;

   // Predicted console state.
   logic [CODE_W-1:0] line_text [RING_LINES*LINE_CHARS];
   logic [LEN_W-1:0]  line_len [RING_LINES];
   int                cur_line;
   int                top_line;
   logic [PIX_W-1:0]  glyph_mem [GLYPH_SLOTS];
   bit                glyph_loaded [GLYPH_SLOTS];

   logic [PIX_W-1:0]  expected_pixel_bytes [$];
   console_cmd_type   directed_rows [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                items_sent = 0;
   bit                steady_stretch = 1'b0;
   bit                mid_drain_done = 1'b0;

   text_console_glyph_renderer_top #(
      .RING_LINES   (RING_LINES),
      .VISIBLE_LINES(VISIBLE_LINES),
      .LINE_CHARS   (LINE_CHARS),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_page       (req_page),
      .req_column     (req_column),
      .req_glyph_index(req_glyph_index),
      .req_glyph_row  (req_glyph_row),
      .req_glyph_bits (req_glyph_bits),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_byte (rsp_pixel_byte)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_console();
      for (int i = 0; i < RING_LINES * LINE_CHARS; i++) line_text[i] = '0;
      for (int i = 0; i < RING_LINES; i++) line_len[i] = '0;
      for (int i = 0; i < GLYPH_SLOTS; i++) begin
         glyph_mem[i] = '0;
         glyph_loaded[i] = 1'b0;
      end
      cur_line = 0;
      top_line = 0;
   endfunction

   function automatic void next_line();
      cur_line = (cur_line + 1) % RING_LINES;
      line_len[cur_line] = '0;
      // The window scrolls once the current line falls outside it.
      if ((cur_line + RING_LINES - top_line) % RING_LINES >= VISIBLE_LINES)
         top_line = (top_line + 1) % RING_LINES;
   endfunction

   // Glyph store slot that feeds pixel row b of a display byte, or -1 when the
   // pixel is blank.
   function automatic int glyph_slot(input logic [2:0] page, input logic [6:0] column,
                                     input int b);
      int y;
      int vis;
      int line;
      int pos;
      int ch;
      y = int'(page) * PAGE_ROWS + b;
      vis = y / GLYPH_HEIGHT;
      pos = int'(column) / GLYPH_WIDTH;
      if (vis >= VISIBLE_LINES) return -1;
      line = (top_line + vis) % RING_LINES;
      if (pos >= int'(line_len[line])) return -1;
      ch = int'(line_text[line * LINE_CHARS + pos]);
      return (ch - int'(FIRST_PRINTABLE)) * GLYPH_HEIGHT + y % GLYPH_HEIGHT;
   endfunction

   function automatic logic [PIX_W-1:0] render_pixel_byte(input logic [2:0] page,
                                                          input logic [6:0] column);
      logic [PIX_W-1:0] pix;
      int slot;
      int bit_sel;
      pix = '0;
      bit_sel = GLYPH_WIDTH - 1 - int'(column) % GLYPH_WIDTH;
      for (int b = 0; b < PAGE_ROWS; b++) begin
         slot = glyph_slot(page, column, b);
         if (slot >= 0) pix[b] = glyph_mem[slot][bit_sel];
      end
      return pix;
   endfunction

   function automatic void console_step(input console_cmd_type cmd);
      int slot;
      case (cmd.op)
         OP_PUT: begin
            if (cmd.code == CODE_NEWLINE) begin
               next_line();
            end else if (cmd.code >= FIRST_PRINTABLE && cmd.code <= LAST_PRINTABLE) begin
               if (int'(line_len[cur_line]) >= LINE_CHARS) next_line();
               line_text[cur_line * LINE_CHARS + int'(line_len[cur_line])] = cmd.code;
               line_len[cur_line] = line_len[cur_line] + 1'b1;
            end
         end
         OP_READ: begin
            if (cmd.known) expected_pixel_bytes.push_back(cmd.known_byte);
            else expected_pixel_bytes.push_back(render_pixel_byte(cmd.page, cmd.column));
         end
         OP_GLYPH: begin
            if (int'(cmd.glyph_index) < GLYPH_COUNT && int'(cmd.glyph_row) < GLYPH_HEIGHT) begin
               slot = int'(cmd.glyph_index) * GLYPH_HEIGHT + int'(cmd.glyph_row);
               glyph_mem[slot] = cmd.glyph_bits;
               glyph_loaded[slot] = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic console_cmd_type random_fields();
      console_cmd_type cmd;
      cmd.op = OP_W'($urandom_range(0, 3));
      cmd.code = CODE_W'($urandom);
      cmd.page = 3'($urandom);
      cmd.column = 7'($urandom);
      cmd.glyph_index = CODE_W'($urandom);
      cmd.glyph_row = ROW_W'($urandom);
      cmd.glyph_bits = PIX_W'($urandom);
      cmd.known = 1'b0;
      cmd.known_byte = '0;
      return cmd;
   endfunction

   function automatic console_cmd_type random_item();
      console_cmd_type cmd;
      int pick;
      int sub;
      cmd = random_fields();
      pick = $urandom_range(0, 99);
      sub = $urandom_range(0, 99);
      if (pick < 50) begin
         cmd.op = OP_PUT;
         if (sub < 6) cmd.code = CODE_NEWLINE;
         else if (sub < 12) cmd.code = (sub < 8) ? 7'd127 : CODE_W'($urandom_range(0, 31));
         else cmd.code = CODE_W'($urandom_range(32, 126));
      end else if (pick < 85) begin
         cmd.op = OP_READ;
         // Half the reads stay near the left edge, where text usually is.
         if (sub < 50) cmd.column = 7'($urandom_range(0, 47));
      end else if (pick < 97) begin
         cmd.op = OP_GLYPH;
         cmd.glyph_index = (sub < 90) ? CODE_W'($urandom_range(0, GLYPH_COUNT - 1))
                                      : CODE_W'($urandom_range(GLYPH_COUNT, 127));
         cmd.glyph_row = ($urandom_range(0, 9) != 0) ? ROW_W'($urandom_range(0, 13))
                                                     : ROW_W'($urandom_range(14, 15));
      end else begin
         cmd.op = OP_UNUSED;
      end
      return cmd;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                          input logic [2:0] page, input logic [6:0] column,
                          input logic [CODE_W-1:0] glyph_index,
                          input logic [ROW_W-1:0] glyph_row,
                          input logic [PIX_W-1:0] glyph_bits,
                          input logic known, input logic [PIX_W-1:0] known_byte);
      console_cmd_type cmd;
      cmd.op = op;
      cmd.code = code;
      cmd.page = page;
      cmd.column = column;
      cmd.glyph_index = glyph_index;
      cmd.glyph_row = glyph_row;
      cmd.glyph_bits = glyph_bits;
      cmd.known = known;
      cmd.known_byte = known_byte;
      directed_rows.push_back(cmd);
   endtask

   task automatic fill_directed_rows();
      // Nothing is visible right after reset.
      add_row(OP_READ, 7'd0, 3'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b1, 8'h00);
      add_row(OP_READ, 7'd127, 3'd7, 7'd127, 7'd127, 4'd15, 8'hFF, 1'b1, 8'h00);
      // Glyph loads outside the store are dropped.
      add_row(OP_GLYPH, 7'd0, 3'd0, 7'd0, 7'd95, 4'd0, 8'hFF, 1'b0, 8'h00);
      add_row(OP_GLYPH, 7'd0, 3'd0, 7'd0, 7'd127, 4'd15, 8'hFF, 1'b0, 8'h00);
      add_row(OP_GLYPH, 7'd0, 3'd0, 7'd0, 7'd0, 4'd14, 8'hAA, 1'b0, 8'h00);
      for (int r = 0; r < PAGE_ROWS; r++)
         add_row(OP_GLYPH, 7'd0, 3'd0, 7'd0, 7'd94, ROW_W'(r),
                 (8'h80 >> r) | 8'h01, 1'b0, 8'h00);
      add_row(OP_PUT, 7'd0, 3'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      add_row(OP_PUT, 7'd127, 3'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      add_row(OP_PUT, LAST_PRINTABLE, 3'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      add_row(OP_READ, 7'd0, 3'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      add_row(OP_READ, 7'd0, 3'd0, 7'd7, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      // Second character position of a one-character line is blank.
      add_row(OP_READ, 7'd0, 3'd0, 7'd8, 7'd0, 4'd0, 8'h00, 1'b1, 8'h00);
      add_row(OP_PUT, CODE_NEWLINE, 3'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      add_row(OP_PUT, FIRST_PRINTABLE, 3'd0, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      add_row(OP_READ, 7'd0, 3'd1, 7'd0, 7'd0, 4'd0, 8'h00, 1'b0, 8'h00);
      add_row(OP_UNUSED, 7'd127, 3'd7, 7'd127, 7'd127, 4'd15, 8'hFF, 1'b0, 8'h00);
      add_row(OP_READ, 7'd0, 3'd7, 7'd0, 7'd0, 4'd0, 8'h00, 1'b1, 8'h00);
   endtask

   task automatic send_item(input console_cmd_type cmd);
      if (!steady_stretch && $urandom_range(0, 99) < 37) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= cmd.op;
      req_char_code <= cmd.code;
      req_page <= cmd.page;
      req_column <= cmd.column;
      req_glyph_index <= cmd.glyph_index;
      req_glyph_row <= cmd.glyph_row;
      req_glyph_bits <= cmd.glyph_bits;
      do @(posedge clock); while (busy);
      items_sent++;
      console_step(cmd);
   endtask

   // A read must never touch a glyph row that was never loaded, so any such
   // row gets a load with random pixels first.
   task automatic send_checked(input console_cmd_type cmd);
      console_cmd_type load;
      int slot;
      if (cmd.op == OP_READ) begin
         for (int b = 0; b < PAGE_ROWS; b++) begin
            slot = glyph_slot(cmd.page, cmd.column, b);
            if (slot >= 0 && !glyph_loaded[slot]) begin
               load = random_fields();
               load.op = OP_GLYPH;
               load.glyph_index = CODE_W'(slot / GLYPH_HEIGHT);
               load.glyph_row = ROW_W'(slot % GLYPH_HEIGHT);
               send_item(load);
            end
         end
      end
      send_item(cmd);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_pixel_bytes.size() != 0);
   endtask

   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_pixel_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected pixel byte %02h", rsp_pixel_byte);
         end else begin
            want = expected_pixel_bytes.pop_front();
            if (rsp_pixel_byte !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("pixel byte mismatch: expected %02h, got %02h",
                           want, rsp_pixel_byte);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("text_console_glyph_renderer_top test failed");
      $finish;
   end

   initial begin
      clear_console();
      fill_directed_rows();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[k]) send_checked(directed_rows[k]);
      hold_until_drained();
      // Glyph loads in front of reads count toward the item budget.
      while (items_sent < ITEM_BUDGET) begin
         steady_stretch = (items_sent >= 500 && items_sent < 800);
         if (!mid_drain_done && items_sent >= 1000) begin
            hold_until_drained();
            mid_drain_done = 1'b1;
         end
         send_checked(random_item());
      end
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixel_bytes.size() == 0)
         $display("text_console_glyph_renderer_top test passed");
      else
         $display("text_console_glyph_renderer_top test failed");
      $finish;
   end

endmodule
